FILE: hdl/dsf_pkg.sv
package dsf_pkg;

  // Fixed field widths of the item formats
  localparam int DATA_W  = 32;
  localparam int GROUP_W = 16;
  localparam int REST_W  = 31;
  localparam int STIFF_W = 31;
  localparam int DAMP_W  = 17;
  localparam int ROOT_W  = 32;

  // Default arithmetic settings
  localparam int FRAC_BITS_DEF  = 16;
  localparam int GROUP_BITS_DEF = 16;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_GROUP_MASK = '0;
  localparam logic [GROUP_W-1:0] GROUP_MASK_RST = '1;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_APPLIED    = 2'd0,
    ST_SKIPPED    = 2'd1,
    ST_DEGENERATE = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rel_pos_x;
    logic signed [DATA_W-1:0] rel_pos_y;
    logic signed [DATA_W-1:0] rel_pos_z;
    logic signed [DATA_W-1:0] rel_vel_x;
    logic signed [DATA_W-1:0] rel_vel_y;
    logic signed [DATA_W-1:0] rel_vel_z;
    logic [REST_W-1:0]        rest_length;
    logic [STIFF_W-1:0]       stiffness;
    logic [DAMP_W-1:0]        damping;
    logic [GROUP_W-1:0]       first_group;
    logic [GROUP_W-1:0]       second_group;
  } spring_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
  } result_item_t;

  // Shift right, rounding toward zero
  function automatic logic signed [63:0] shr_tz(input logic signed [63:0] x, input int sh);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = m >> sh;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to the signed 32-bit range; top bit flags a clamp
  function automatic logic [DATA_W:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return {1'b1, S32_MAX};
    end else if (x < -64'sd2147483648) begin
      return {1'b1, S32_MIN};
    end
    return {1'b0, x[DATA_W-1:0]};
  endfunction

endpackage

FILE: hdl/dsf_stream_if.sv
interface dsf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/damped_spring_force.sv
// Arithmetic is fixed point, Q16.16 at the default FRAC_BITS of 16.
// Throughput: one item per cycle; the square root (32 stages) and the dividers
// (one quotient bit per stage) are fully pipelined, and the whole pipe halts
// only while a result waits at the output register.
// Reset (rst, synchronous): empties the pipe, sets spring_group_mask to 0xFFFF.
module damped_spring_force #(
  parameter int FRAC_BITS  = dsf_pkg::FRAC_BITS_DEF,
  parameter int GROUP_BITS = dsf_pkg::GROUP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  dsf_stream_if.sink                  spring,
  dsf_stream_if.source                result
);

  localparam int DW    = dsf_pkg::DATA_W;
  localparam int GW    = dsf_pkg::GROUP_W;
  localparam int UW    = FRAC_BITS + 2;
  localparam int UQW   = FRAC_BITS + 1;
  localparam int EW    = DW + FRAC_BITS;
  localparam int OW    = FRAC_BITS + 1;
  localparam int HW    = (EW + 1) / 2;
  localparam int LW    = EW - HW;
  localparam int PW    = UW + DW;
  localparam int RVW   = 34;
  localparam int PRODW = EW + dsf_pkg::STIFF_W;
  localparam int T2W   = RVW + OW + 1;
  localparam int FPW   = DW + UW;
  localparam logic [DW-1:0] ONE = 32'(1) << FRAC_BITS;
  localparam logic [GW-1:0] GMASK =
    (GROUP_BITS >= GW) ? '1 : GW'((32'd1 << GROUP_BITS) - 32'd1);

  typedef struct packed {
    logic                                skip;
    logic [2:0]                          dneg;
    logic [2:0][DW-1:0]                  dmag;
    logic [2:0][DW-1:0]                  vel;
    logic [dsf_pkg::REST_W-1:0]          l0;
    logic [dsf_pkg::STIFF_W-1:0]         k;
    logic [OW-1:0]                       omc;
  } side_a_t;

  typedef struct packed {
    logic                                skip;
    logic                                degen;
    logic [2:0]                          dneg;
    logic [2:0][DW-1:0]                  vel;
    logic [dsf_pkg::REST_W-1:0]          l0;
    logic [dsf_pkg::STIFF_W-1:0]         k;
    logic [OW-1:0]                       omc;
    logic                                eneg;
    logic [DW-1:0]                       ediff;
  } side_b_t;

  typedef struct packed {
    logic                                skip;
    logic                                degen;
    logic [2:0]                          dneg;
    logic [2:0][UQW-1:0]                 uq;
    logic [2:0][DW-1:0]                  vel;
    logic [dsf_pkg::STIFF_W-1:0]         k;
    logic [OW-1:0]                       omc;
    logic                                eneg;
  } side_c_t;

  // Configuration register
  logic [GW-1:0] group_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_mask <= dsf_pkg::GROUP_MASK_RST;
    end else if (psel && penable && pwrite
                 && paddr[dsf_pkg::PADDR_W-1:2] == dsf_pkg::REG_GROUP_MASK) begin
      group_mask <= pwdata[GW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[dsf_pkg::PADDR_W-1:2] == dsf_pkg::REG_GROUP_MASK) begin
      prdata = 32'(group_mask);
    end
  end

  assign pready = 1'b1;

  // Whole pipe advances unless a result waits at the output
  logic adv;
  logic res_vld;

  assign adv          = !res_vld || result.ready;
  assign spring.ready = adv;

  // Stage 1: magnitudes, mask test, damping factor
  logic [2:0][DW-1:0] in_d;
  logic [2:0][DW-1:0] in_v;
  logic [DW-1:0]      c_ext;
  logic [DW-1:0]      c_clamp;
  side_a_t            in_side;

  assign in_d = {spring.data.rel_pos_z, spring.data.rel_pos_y, spring.data.rel_pos_x};
  assign in_v = {spring.data.rel_vel_z, spring.data.rel_vel_y, spring.data.rel_vel_x};
  assign c_ext   = DW'(spring.data.damping);
  assign c_clamp = (c_ext > ONE) ? ONE : c_ext;

  always_comb begin
    in_side.skip = (spring.data.first_group & spring.data.second_group
                    & group_mask & GMASK) == '0;
    for (int i = 0; i < 3; i++) begin
      in_side.dneg[i] = in_d[i][DW-1];
      in_side.dmag[i] = in_d[i][DW-1] ? (~in_d[i] + 1'b1) : in_d[i];
    end
    in_side.vel = in_v;
    in_side.l0  = spring.data.rest_length;
    in_side.k   = spring.data.stiffness;
    in_side.omc = OW'(ONE - c_clamp);
  end

  logic    s1_vld;
  side_a_t s1_side;
  logic    s2_vld;
  side_a_t s2_side;
  logic [2:0][63:0] s2_sq;
  logic    s3_vld;
  side_a_t s3_side;
  logic [63:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= spring.valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  // Stages 2 and 3: squares, then their sum
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= in_side;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= s1_side.dmag[i] * s1_side.dmag[i];
      end
      s2_side <= s1_side;
      s3_sum  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
      s3_side <= s2_side;
    end
  end

  // Length
  logic                       sq_vld;
  logic [dsf_pkg::ROOT_W-1:0] sq_root;
  side_a_t                    sq_side;

  dsf_isqrt #(
    .SIDE_W($bits(side_a_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s3_vld),
    .in_sq    (s3_sum),
    .in_side  (s3_side),
    .out_valid(sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Stage 4: degenerate test and length minus rest length
  logic [DW:0] ldiff;
  assign ldiff = {1'b0, sq_root} - (DW + 1)'(sq_side.l0);

  logic              s4_vld;
  side_a_t           s4_side;
  logic [DW-1:0]     s4_len;
  side_b_t           s4_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side    <= sq_side;
      s4_len     <= sq_root;
      s4_b.skip  <= sq_side.skip;
      s4_b.degen <= (sq_root == '0) || (sq_side.l0 == '0);
      s4_b.dneg  <= sq_side.dneg;
      s4_b.vel   <= sq_side.vel;
      s4_b.l0    <= sq_side.l0;
      s4_b.k     <= sq_side.k;
      s4_b.omc   <= sq_side.omc;
      s4_b.eneg  <= ldiff[DW];
      s4_b.ediff <= ldiff[DW] ? DW'(-ldiff) : ldiff[DW-1:0];
    end
  end

  // Unit direction magnitudes: |d| << FRAC_BITS over length
  logic [2:0][EW-1:0]  ud_num;
  logic                ud_vld;
  logic [2:0][UQW-1:0] ud_q;
  side_b_t             ud_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ud_num[i] = {s4_side.dmag[i], {FRAC_BITS{1'b0}}};
    end
  end

  dsf_div #(
    .LANES (3),
    .NUM_W (EW),
    .DEN_W (DW),
    .Q_W   (UQW),
    .SIDE_W($bits(side_b_t))
  ) u_div_dir (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s4_vld),
    .in_num   (ud_num),
    .in_den   (s4_len),
    .in_side  (s4_b),
    .out_valid(ud_vld),
    .out_q    (ud_q),
    .out_side (ud_side)
  );

  // Strain magnitude: |L - L0| << FRAC_BITS over rest length
  logic [0:0][EW:0]   ed_num;
  side_c_t            ed_in;
  logic               ed_vld;
  logic [0:0][EW-1:0] ed_q;
  side_c_t            ed_side;

  assign ed_num[0] = {1'b0, ud_side.ediff, {FRAC_BITS{1'b0}}};

  always_comb begin
    ed_in.skip  = ud_side.skip;
    ed_in.degen = ud_side.degen;
    ed_in.dneg  = ud_side.dneg;
    ed_in.uq    = ud_q;
    ed_in.vel   = ud_side.vel;
    ed_in.k     = ud_side.k;
    ed_in.omc   = ud_side.omc;
    ed_in.eneg  = ud_side.eneg;
  end

  dsf_div #(
    .LANES (1),
    .NUM_W (EW + 1),
    .DEN_W (dsf_pkg::REST_W),
    .Q_W   (EW),
    .SIDE_W($bits(side_c_t))
  ) u_div_strain (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (ud_vld),
    .in_num   (ed_num),
    .in_den   (ud_side.l0),
    .in_side  (ed_in),
    .out_valid(ed_vld),
    .out_q    (ed_q),
    .out_side (ed_side)
  );

  // Stage 5: signed unit vector, u*v products, strain*stiffness halves
  logic signed [UW-1:0] u_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i] = $signed(UW'(ed_side.uq[i]));
      if (ed_side.dneg[i]) begin
        u_c[i] = -u_c[i];
      end
    end
  end

  logic                 s5_vld;
  logic signed [UW-1:0] s5_u [3];
  logic signed [PW-1:0] s5_p [3];
  logic [HW+dsf_pkg::STIFF_W-1:0] s5_kl;
  logic [LW+dsf_pkg::STIFF_W-1:0] s5_kh;
  logic                 s5_skip;
  logic                 s5_degen;
  logic [OW-1:0]        s5_omc;
  logic                 s5_eneg;

  // Stage 6: dot product and full strain*stiffness product
  logic signed [63:0]   dot;
  logic [PRODW-1:0]     kprod;

  assign dot   = s5_p[0] + s5_p[1] + s5_p[2];
  assign kprod = (PRODW'(s5_kh) << HW) + PRODW'(s5_kl);

  logic                  s6_vld;
  logic signed [RVW-1:0] s6_rv;
  logic                  s6_ovf;
  logic [63:0]           s6_t1m;
  logic signed [UW-1:0]  s6_u [3];
  logic                  s6_skip;
  logic                  s6_degen;
  logic [OW-1:0]         s6_omc;
  logic                  s6_eneg;

  // Stage 7: damping product and signed stiffness term
  logic                  s7_vld;
  logic signed [T2W-1:0] s7_t2p;
  logic signed [63:0]    s7_term1;
  logic                  s7_ovf;
  logic                  s7_eneg;
  logic signed [UW-1:0]  s7_u [3];
  logic                  s7_skip;
  logic                  s7_degen;

  // Stage 8: damping term
  logic                  s8_vld;
  logic signed [63:0]    s8_term2;
  logic signed [63:0]    s8_term1;
  logic                  s8_ovf;
  logic                  s8_eneg;
  logic signed [UW-1:0]  s8_u [3];
  logic                  s8_skip;
  logic                  s8_degen;

  // Stage 9: clamped coefficient
  logic signed [63:0]    s_sum;
  logic [DW:0]           s_sat;

  assign s_sum = s8_term1 + s8_term2;
  assign s_sat = dsf_pkg::sat32(s_sum);

  logic                  s9_vld;
  logic signed [DW-1:0]  s9_s;
  logic                  s9_sat;
  logic signed [UW-1:0]  s9_u [3];
  logic                  s9_skip;
  logic                  s9_degen;

  // Stage 10: force products
  logic                  s10_vld;
  logic signed [FPW-1:0] s10_fp [3];
  logic                  s10_sat;
  logic                  s10_skip;
  logic                  s10_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld  <= 1'b0;
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
    end else if (adv) begin
      s5_vld  <= ed_vld;
      s6_vld  <= s5_vld;
      s7_vld  <= s6_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_u[i]   <= u_c[i];
        s5_p[i]   <= u_c[i] * $signed(ed_side.vel[i]);
        s6_u[i]   <= s5_u[i];
        s7_u[i]   <= s6_u[i];
        s8_u[i]   <= s7_u[i];
        s9_u[i]   <= s8_u[i];
        s10_fp[i] <= s9_s * s9_u[i];
      end
      s5_kl    <= ed_q[0][HW-1:0] * ed_side.k;
      s5_kh    <= ed_q[0][EW-1:HW] * ed_side.k;
      s5_skip  <= ed_side.skip;
      s5_degen <= ed_side.degen;
      s5_omc   <= ed_side.omc;
      s5_eneg  <= ed_side.eneg;

      s6_rv    <= RVW'(dsf_pkg::shr_tz(dot, FRAC_BITS));
      s6_ovf   <= |kprod[PRODW-1:63];
      s6_t1m   <= 64'(kprod[62:0] >> FRAC_BITS);
      s6_skip  <= s5_skip;
      s6_degen <= s5_degen;
      s6_omc   <= s5_omc;
      s6_eneg  <= s5_eneg;

      s7_t2p   <= s6_rv * $signed({1'b0, s6_omc});
      s7_term1 <= s6_eneg ? -$signed(s6_t1m) : $signed(s6_t1m);
      s7_ovf   <= s6_ovf;
      s7_eneg  <= s6_eneg;
      s7_skip  <= s6_skip;
      s7_degen <= s6_degen;

      s8_term2 <= dsf_pkg::shr_tz(64'(s7_t2p), FRAC_BITS);
      s8_term1 <= s7_term1;
      s8_ovf   <= s7_ovf;
      s8_eneg  <= s7_eneg;
      s8_skip  <= s7_skip;
      s8_degen <= s7_degen;

      if (s8_ovf) begin
        s9_s   <= s8_eneg ? $signed(dsf_pkg::S32_MIN) : $signed(dsf_pkg::S32_MAX);
        s9_sat <= 1'b1;
      end else begin
        s9_s   <= $signed(s_sat[DW-1:0]);
        s9_sat <= s_sat[DW];
      end
      s9_skip  <= s8_skip;
      s9_degen <= s8_degen;

      s10_sat   <= s9_sat;
      s10_skip  <= s9_skip;
      s10_degen <= s9_degen;
    end
  end

  // Output stage: scale, clamp, pick status
  logic [2:0][DW:0] f_sat;
  logic             any_sat;
  dsf_pkg::result_item_t res_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_sat[i] = dsf_pkg::sat32(dsf_pkg::shr_tz(64'(s10_fp[i]), FRAC_BITS));
    end
    any_sat = s10_sat | f_sat[0][DW] | f_sat[1][DW] | f_sat[2][DW];
    res_next.force_x = $signed(f_sat[0][DW-1:0]);
    res_next.force_y = $signed(f_sat[1][DW-1:0]);
    res_next.force_z = $signed(f_sat[2][DW-1:0]);
    priority if (s10_skip) begin
      res_next.status  = dsf_pkg::ST_SKIPPED;
      res_next.force_x = '0;
      res_next.force_y = '0;
      res_next.force_z = '0;
    end else if (s10_degen) begin
      res_next.status  = dsf_pkg::ST_DEGENERATE;
      res_next.force_x = '0;
      res_next.force_y = '0;
      res_next.force_z = '0;
    end else if (any_sat) begin
      res_next.status = dsf_pkg::ST_SATURATED;
    end else begin
      res_next.status = dsf_pkg::ST_APPLIED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= s10_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.data <= res_next;
    end
  end

  assign result.valid = res_vld;

  // A skipped or degenerate spring carries no force
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.data.status == dsf_pkg::ST_SKIPPED
                      || result.data.status == dsf_pkg::ST_DEGENERATE))
    |-> (result.data.force_x == '0 && result.data.force_y == '0
         && result.data.force_z == '0))
    else $error("force not zero on skipped or degenerate spring");

  // A waiting result halts intake
  a_stall_halts: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !spring.ready)
    else $error("input taken while result stalled");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule

FILE: hdl/dsf_isqrt.sv
// Pipelined integer square root: one result bit per stage
module dsf_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [63:0]                in_sq,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [dsf_pkg::ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int STEPS = dsf_pkg::ROOT_W;

  logic [63:0]       num  [1:STEPS];
  logic [63:0]       root [1:STEPS];
  logic              vld  [1:STEPS];
  logic [SIDE_W-1:0] side [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0]       prev_num;
    logic [63:0]       prev_root;
    logic              prev_vld;
    logic [SIDE_W-1:0] prev_side;
    logic [63:0]       trial;
    logic              take;

    if (j == 0) begin : g_first
      assign prev_num  = in_sq;
      assign prev_root = '0;
      assign prev_vld  = in_valid;
      assign prev_side = in_side;
    end else begin : g_next
      assign prev_num  = num[j];
      assign prev_root = root[j];
      assign prev_vld  = vld[j];
      assign prev_side = side[j];
    end

    // Try the next root bit against the remainder
    assign trial = prev_root + BIT;
    assign take  = prev_num >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[j+1]  <= take ? prev_num - trial : prev_num;
        root[j+1] <= take ? (prev_root >> 1) + BIT : prev_root >> 1;
        side[j+1] <= prev_side;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_root  = root[STEPS][dsf_pkg::ROOT_W-1:0];
  assign out_side  = side[STEPS];

endmodule

FILE: hdl/dsf_div.sv
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one divisor. The top NUM_W-Q_W dividend bits must be below den.
module dsf_div #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]            in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_q,
  output logic [SIDE_W-1:0]           out_side
);

  logic [LANES-1:0][DEN_W-1:0] rem  [1:Q_W];
  logic [LANES-1:0][Q_W-1:0]   low  [1:Q_W];
  logic [DEN_W-1:0]            den  [1:Q_W];
  logic                        vld  [1:Q_W];
  logic [SIDE_W-1:0]           side [1:Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic [LANES-1:0][DEN_W-1:0] prev_rem;
    logic [LANES-1:0][Q_W-1:0]   prev_low;
    logic [DEN_W-1:0]            prev_den;
    logic                        prev_vld;
    logic [SIDE_W-1:0]           prev_side;
    logic [LANES-1:0][DEN_W-1:0] next_rem;
    logic [LANES-1:0][Q_W-1:0]   next_low;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane_in
        assign prev_rem[l] = DEN_W'(in_num[l][NUM_W-1:Q_W]);
        assign prev_low[l] = in_num[l][Q_W-1:0];
      end
      assign prev_den  = in_den;
      assign prev_vld  = in_valid;
      assign prev_side = in_side;
    end else begin : g_next
      assign prev_rem  = rem[j];
      assign prev_low  = low[j];
      assign prev_den  = den[j];
      assign prev_vld  = vld[j];
      assign prev_side = side[j];
    end

    // Bring down one dividend bit and subtract where it fits
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] trial;
      logic           ge;
      assign trial       = {prev_rem[l], prev_low[l][Q_W-1]};
      assign ge          = trial >= {1'b0, prev_den};
      assign next_rem[l] = ge ? DEN_W'(trial - {1'b0, prev_den}) : trial[DEN_W-1:0];
      assign next_low[l] = {prev_low[l][Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= next_rem;
        low[j+1]  <= next_low;
        den[j+1]  <= prev_den;
        side[j+1] <= prev_side;
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_q     = low[Q_W];
  assign out_side  = side[Q_W];

endmodule

FILE: tb/sv/tb_damped_spring_force.sv
`timescale 1ns / 1ps

module tb_damped_spring_force;

  localparam longint ONE = 64'sd65536;
  localparam logic [dsf_pkg::PADDR_W-1:0] MASK_ADDR = {dsf_pkg::REG_GROUP_MASK, 2'b00};
  localparam int DRAIN_CYCLES = 130;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    dsf_pkg::spring_item_t item;
    bit                    typed;
    dsf_pkg::result_item_t want;
  } spring_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dsf_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dsf_stream_if #(.T(dsf_pkg::spring_item_t)) spring_if ();
  dsf_stream_if #(.T(dsf_pkg::result_item_t)) result_if ();

  logic [dsf_pkg::GROUP_W-1:0] group_mask = dsf_pkg::GROUP_MASK_RST;
  dsf_pkg::result_item_t       force_queue[$];
  int                          error_count = 0;
  int                          idle_cycles = 0;
  int                          sink_hold = 0;
  bit                          no_idle = 1'b0;

  damped_spring_force dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .spring(spring_if), .result(result_if)
  );

  always #6 clk = ~clk;

  initial begin
    spring_if.valid = 1'b0;
    spring_if.data = '0;
    result_if.ready = 1'b0;
  end

  // Shift right by the fraction bits, truncating toward zero
  function automatic longint frac_shift(longint x);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = m >> 16;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint x, inout bit hit);
    if (x > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Expected force for one spring under the current group mask
  function automatic dsf_pkg::result_item_t predict_force(dsf_pkg::spring_item_t it,
                                                          logic [dsf_pkg::GROUP_W-1:0] mask);
    longint d[3], v[3], u[3], f[3];
    longint unsigned sq, mg, len, rem, bt, me, ku;
    longint l0, k, c, e, dot, rv, term1, term2, s;
    bit hit;
    dsf_pkg::result_item_t r;
    r = '0;
    hit = 1'b0;
    d[0] = it.rel_pos_x; d[1] = it.rel_pos_y; d[2] = it.rel_pos_z;
    v[0] = it.rel_vel_x; v[1] = it.rel_vel_y; v[2] = it.rel_vel_z;
    l0 = longint'({33'd0, it.rest_length});
    k = longint'({33'd0, it.stiffness});
    c = longint'({47'd0, it.damping});
    if ((it.first_group & it.second_group & mask) == '0) begin
      r.status = dsf_pkg::ST_SKIPPED;
      return r;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (d[i] < 0) ? longint'(-d[i]) : d[i];
      sq += mg * mg;
    end
    // Bitwise integer square root, floor
    rem = sq;
    len = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= len + bt) begin
        rem = rem - (len + bt);
        len = (len >> 1) + bt;
      end else begin
        len = len >> 1;
      end
      bt = bt >> 2;
    end
    if (len == 0 || l0 == 0) begin
      r.status = dsf_pkg::ST_DEGENERATE;
      return r;
    end
    for (int i = 0; i < 3; i++) u[i] = (d[i] * ONE) / longint'(len);
    e = ((longint'(len) - l0) * ONE) / l0;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += u[i] * v[i];
    rv = frac_shift(dot);
    if (c > ONE) c = ONE;
    term2 = frac_shift(rv * (ONE - c));
    me = (e < 0) ? longint'(-e) : e;
    ku = k;
    if (ku != 0 && me > 64'h7FFF_FFFF_FFFF_FFFF / ku) begin
      hit = 1'b1;
      s = (e < 0) ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      term1 = longint'((me * ku) >> 16);
      if (e < 0) term1 = -term1;
      s = clamp32(term1 + term2, hit);
    end
    for (int i = 0; i < 3; i++) f[i] = clamp32(frac_shift(s * u[i]), hit);
    r.status = hit ? dsf_pkg::ST_SATURATED : dsf_pkg::ST_APPLIED;
    r.force_x = f[0][31:0];
    r.force_y = f[1][31:0];
    r.force_z = f[2][31:0];
    return r;
  endfunction

  function automatic dsf_pkg::spring_item_t make_spring(longint px, longint py, longint pz,
                                                       longint vx, longint vy, longint vz,
                                                       longint l0, longint k, longint c,
                                                       longint g1, longint g2);
    dsf_pkg::spring_item_t it;
    it.rel_pos_x = px[31:0]; it.rel_pos_y = py[31:0]; it.rel_pos_z = pz[31:0];
    it.rel_vel_x = vx[31:0]; it.rel_vel_y = vy[31:0]; it.rel_vel_z = vz[31:0];
    it.rest_length = l0[30:0];
    it.stiffness = k[30:0];
    it.damping = c[16:0];
    it.first_group = g1[15:0];
    it.second_group = g2[15:0];
    return it;
  endfunction

  // Mostly plausible springs of varied scale; some items fully random
  function automatic dsf_pkg::spring_item_t random_spring();
    dsf_pkg::spring_item_t it;
    int ps, vs, b;
    if ($urandom_range(0, 4) == 0) begin
      it = make_spring($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom_range(0, 131071), $urandom, $urandom);
    end else begin
      ps = $urandom_range(2, 20);
      vs = $urandom_range(2, 24);
      it.rel_pos_x = $signed($urandom) >>> ps;
      it.rel_pos_y = $signed($urandom) >>> ps;
      it.rel_pos_z = $signed($urandom) >>> ps;
      it.rel_vel_x = $signed($urandom) >>> vs;
      it.rel_vel_y = $signed($urandom) >>> vs;
      it.rel_vel_z = $signed($urandom) >>> vs;
      it.rest_length = 31'($urandom >> $urandom_range(ps, 24));
      it.stiffness = 31'($urandom >> $urandom_range(1, 24));
      it.damping = 17'($urandom_range(0, 65536));
      b = $urandom_range(0, 15);
      it.first_group = 16'($urandom | (1 << b));
      it.second_group = 16'($urandom | (1 << b));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Drive one spring, waiting a random gap first; queue its force on acceptance
  task automatic send_spring(dsf_pkg::spring_item_t it, bit typed,
                             dsf_pkg::result_item_t want);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      spring_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    spring_if.data <= it;
    spring_if.valid <= 1'b1;
    do @(posedge clk); while (!spring_if.ready);
    force_queue.push_back(typed ? want : predict_force(it, group_mask));
  endtask

  task automatic drain_forces();
    spring_if.valid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access cycle; write mask then read it back
  task automatic write_mask(logic [dsf_pkg::GROUP_W-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= MASK_ADDR; pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    group_mask = value;
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != {16'd0, value}) report_mismatch("spring_group_mask", prdata, value);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_spring(random_spring(), 1'b0, '0);
  endtask

  // Sink: stall a random number of cycles after each item
  always @(posedge clk) begin
    if (result_if.valid && result_if.ready) begin
      if (force_queue.size() == 0) begin
        report_mismatch("unexpected item", result_if.data.status, 0);
      end else begin
        if (result_if.data.status != force_queue[0].status)
          report_mismatch("status", result_if.data.status, force_queue[0].status);
        if (result_if.data.force_x != force_queue[0].force_x)
          report_mismatch("force_x", result_if.data.force_x, force_queue[0].force_x);
        if (result_if.data.force_y != force_queue[0].force_y)
          report_mismatch("force_y", result_if.data.force_y, force_queue[0].force_y);
        if (result_if.data.force_z != force_queue[0].force_z)
          report_mismatch("force_z", result_if.data.force_z, force_queue[0].force_z);
        void'(force_queue.pop_front());
      end
      sink_hold = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    end else if (sink_hold > 0) begin
      sink_hold--;
    end
    result_if.ready <= !rst && sink_hold == 0;
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((spring_if.valid && spring_if.ready) || (result_if.valid && result_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    spring_row_t rows[$];
    spring_row_t row;
    dsf_pkg::result_item_t zero_force;
    zero_force = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed springs: typed where obvious, predicted otherwise
    row.typed = 1'b1;
    row.want = zero_force; row.want.status = dsf_pkg::ST_SKIPPED;
    row.item = make_spring(ONE, ONE, ONE, 0, 0, 0, ONE, ONE, 0, 0, 16'hFFFF);
    rows.push_back(row);
    row.item = make_spring(ONE, 0, 0, 5, 5, 5, ONE, ONE, 0, 16'h00F0, 16'h0F00);
    rows.push_back(row);
    row.want.status = dsf_pkg::ST_DEGENERATE;
    row.item = make_spring(0, 0, 0, ONE, ONE, ONE, ONE, ONE, 0, 1, 1);
    rows.push_back(row);
    row.item = make_spring(ONE, ONE, 0, 0, 0, 0, 0, ONE, 0, 16'hFFFF, 16'hFFFF);
    rows.push_back(row);
    row.want.status = dsf_pkg::ST_APPLIED;
    row.item = make_spring(ONE, 0, 0, 0, 0, 0, ONE, ONE, 0, 1, 1);
    rows.push_back(row);
    row.want.force_x = 32'(ONE);
    row.item = make_spring(2 * ONE, 0, 0, 0, 0, 0, ONE, ONE, 0, 3, 2);
    rows.push_back(row);
    row.typed = 1'b0;
    row.item = make_spring(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 31'h7FFFFFFF, 0,
                           16'hFFFF, 16'hFFFF);
    rows.push_back(row);
    row.item = make_spring(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -64'sd2147483648,
                           -64'sd2147483648, -64'sd2147483648, 31'h7FFFFFFF, 31'h7FFFFFFF,
                           65536, 16'h8000, 16'h8000);
    rows.push_back(row);
    row.item = make_spring(3 * ONE, 4 * ONE, 0, ONE, -ONE, 2 * ONE, 2 * ONE, ONE, 131071,
                           16'h0101, 16'h0100);
    rows.push_back(row);
    row.item = make_spring(0, 0, 5 * ONE, 0, 0, 7 * ONE, 4 * ONE, 2 * ONE, 0, 4, 4);
    rows.push_back(row);
    row.item = make_spring(0, ONE / 2, 0, 0, -ONE, 0, ONE, 31'h00FF0000, 32768, 1, 1);
    rows.push_back(row);
    row.item = make_spring(-ONE, 2, -3, 32'h7FFFFFFF, 0, -64'sd2147483648, 1, 0,
                           65535, 16'h0002, 16'h0003);
    rows.push_back(row);
    for (int n = 0; n < 4; n++) begin
      row.item = make_spring($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom_range(0, 131071), 16'hFFFF, 16'hFFFF);
      rows.push_back(row);
    end
    foreach (rows[i]) send_spring(rows[i].item, rows[i].typed, rows[i].want);
    random_phase(400);
    drain_forces();

    // Mask cleared: every spring skipped
    write_mask('0);
    random_phase(100);
    drain_forces();

    write_mask(16'h0001);
    random_phase(350);
    drain_forces();

    write_mask(16'($urandom));
    random_phase(400);
    drain_forces();

    // Full mask, no idling on either side, then random idling again
    write_mask(16'hFFFF);
    no_idle = 1'b1;
    random_phase(300);
    no_idle = 1'b0;
    random_phase(330);
    drain_forces();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
